// ===== hdl/rlss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_pkg
// Shared types and constants of the raster line scroll sequencer.
// ----------------------------------------------------------------------------
package rlss_pkg;

  // Operation codes of an input transaction
  typedef enum logic [2:0] {
    OP_FRAME_START = 3'd0,
    OP_LINE_EVENT  = 3'd1,
    OP_TABLE_WRITE = 3'd2,
    OP_SELECT_SIDE = 3'd3,
    OP_READ_ENTRY  = 3'd4
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CRT_TIMING    = 3'd0,
    CFG_DISPLAY_START = 3'd1,
    CFG_LINE_STEP     = 3'd2,
    CFG_SPRITE_OFFSET = 3'd3,
    CFG_END_LINE_LOW  = 3'd4,
    CFG_END_LINE_HIGH = 3'd5,
    CFG_READ_LIMIT    = 3'd6
  } cfg_reg_e;

  // scroll_update codes
  localparam logic [1:0] UPD_NONE   = 2'd0;
  localparam logic [1:0] UPD_XY     = 2'd1;
  localparam logic [1:0] UPD_Y_ONLY = 2'd2;

  // line_irq_control codes
  localparam logic [1:0] IRQ_KEEP  = 2'd0;
  localparam logic [1:0] IRQ_START = 2'd1;
  localparam logic [1:0] IRQ_STOP  = 2'd2;

  // back_layer codes
  localparam logic [1:0] BACK_KEEP = 2'd0;
  localparam logic [1:0] BACK_ON   = 2'd1;
  localparam logic [1:0] BACK_OFF  = 2'd2;

  localparam logic [15:0] TOP_SCROLL_X = 16'd256;
  localparam logic [15:0] PARKED_LINE  = 16'd255;

  // Register reset values
  localparam logic       RST_CRT_TIMING    = 1'b0;
  localparam logic [9:0] RST_DISPLAY_START = 10'd0;
  localparam logic [7:0] RST_LINE_STEP     = 8'd1;
  localparam logic [7:0] RST_SPRITE_OFFSET = 8'd16;
  localparam logic [9:0] RST_END_LINE_LOW  = 10'd256;
  localparam logic [9:0] RST_END_LINE_HIGH = 10'd352;  // 320 + 32
  localparam logic [9:0] RST_READ_LIMIT    = 10'd512;

  // One table entry
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] pattern;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture item, access table
    logic commit;  // update state, load result register
  } ctrl_cmd_t;

endpackage

// ===== hdl/rlss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_ctrl
// Two-state controller: accept a transaction, then execute it into the
// result register once that register is free.
// ----------------------------------------------------------------------------
module rlss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rlss_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_load_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == S_EXEC))
    else $error("accepted transaction did not move to execute");

  a_commit_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote an untaken result");

  a_commit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_no_load_and_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.commit))
    else $error("load and commit in the same cycle");
`endif

endmodule

// ===== hdl/rlss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlss_datapath
// Scroll table, configuration registers, sequencer state and result
// register.
// ----------------------------------------------------------------------------
module rlss_datapath #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rlss_pkg::ctrl_cmd_t cmd_i,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [9:0]          cfg_data_i,
  // input transaction payload
  input  logic [2:0]          operation_i,
  input  logic                side_i,
  input  logic [8:0]          entry_index_i,
  input  logic [15:0]         entry_x_i,
  input  logic [15:0]         entry_y_i,
  input  logic [15:0]         entry_pattern_i,
  // result payload
  output logic [1:0]          scroll_update_o,
  output logic [15:0]         scroll_x_o,
  output logic [15:0]         scroll_y_o,
  output logic [15:0]         next_line_o,
  output logic [1:0]          line_irq_control_o,
  output logic [1:0]          back_layer_o,
  output logic                flip_request_o,
  output logic                sequence_done_o,
  output logic [15:0]         read_x_o,
  output logic [15:0]         read_y_o,
  output logic [15:0]         read_pattern_o,
  output logic                read_clamped_o
);

  // Depth is a power of two; indexes wrap by truncation.
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int WW = (AW > 9)  ? AW : 9;
  localparam int RW = (AW > 10) ? AW : 10;
  localparam logic [AW-1:0] RES_START = AW'(TABLE_DEPTH - 2);
  localparam logic [AW-1:0] RES_TOP   = AW'(TABLE_DEPTH - 4);

  // configuration
  logic       crt_timing_q;
  logic [9:0] display_start_q;
  logic [7:0] line_step_q;
  logic [7:0] sprite_offset_q;
  logic [9:0] end_line_low_q;
  logic [9:0] end_line_high_q;
  logic [9:0] read_limit_q;

  // sequencer state
  logic        armed_q, armed_d;
  logic        in_progress_q, in_progress_d;
  logic        first_line_q, first_line_d;
  logic        selected_side_q, selected_side_d;
  logic        active_side_q, active_side_d;
  logic [15:0] start_line_q, start_line_d;
  logic [15:0] line_count_q, line_count_d;

  // captured transaction
  logic [2:0]  op_q;
  logic        side_q;
  logic        clamped_q;
  rlss_pkg::entry_t rd_a_q, rd_b_q;

  rlss_pkg::entry_t table_mem [TABLE_DEPTH];

  // ---- address generation at load ----
  logic [AW-1:0] addr_a, addr_b, waddr;
  logic [15:0]   line_rel;
  logic [9:0]    rd_idx, rd_idx_lim;
  logic          rd_clamp;
  logic [RW-1:0] rd_idx_ext;
  logic [WW-1:0] wr_idx_ext;

  always_comb begin
    line_rel   = line_count_q - start_line_q + 16'(active_side_q);
    rd_idx     = {entry_index_i, selected_side_q};
    rd_clamp   = (rd_idx >= read_limit_q);
    rd_idx_lim = rd_idx;
    if (rd_clamp) begin
      rd_idx_lim = (read_limit_q == 10'd0) ? 10'd0 : read_limit_q - 10'd1;
    end
    rd_idx_ext = RW'(rd_idx_lim);
    wr_idx_ext = WW'(entry_index_i);
    waddr      = wr_idx_ext[AW-1:0];
    addr_b     = RES_TOP + AW'(selected_side_q);
    unique case (rlss_pkg::op_e'(operation_i))
      rlss_pkg::OP_FRAME_START: addr_a = RES_START + AW'(selected_side_q);
      rlss_pkg::OP_READ_ENTRY:  addr_a = rd_idx_ext[AW-1:0];
      default:                  addr_a = line_rel[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (rlss_pkg::op_e'(operation_i) == rlss_pkg::OP_TABLE_WRITE) begin
        table_mem[waddr] <= '{x: entry_x_i, y: entry_y_i, pattern: entry_pattern_i};
      end
      rd_a_q    <= table_mem[addr_a];
      rd_b_q    <= table_mem[addr_b];
      op_q      <= operation_i;
      side_q    <= side_i;
      clamped_q <= rd_clamp;
    end
  end

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crt_timing_q    <= rlss_pkg::RST_CRT_TIMING;
      display_start_q <= rlss_pkg::RST_DISPLAY_START;
      line_step_q     <= rlss_pkg::RST_LINE_STEP;
      sprite_offset_q <= rlss_pkg::RST_SPRITE_OFFSET;
      end_line_low_q  <= rlss_pkg::RST_END_LINE_LOW;
      end_line_high_q <= rlss_pkg::RST_END_LINE_HIGH;
      read_limit_q    <= rlss_pkg::RST_READ_LIMIT;
    end else if (cfg_we_i) begin
      unique case (rlss_pkg::cfg_reg_e'(cfg_index_i))
        rlss_pkg::CFG_CRT_TIMING:    crt_timing_q    <= cfg_data_i[0];
        rlss_pkg::CFG_DISPLAY_START: display_start_q <= cfg_data_i;
        rlss_pkg::CFG_LINE_STEP:     line_step_q     <= cfg_data_i[7:0];
        rlss_pkg::CFG_SPRITE_OFFSET: sprite_offset_q <= cfg_data_i[7:0];
        rlss_pkg::CFG_END_LINE_LOW:  end_line_low_q  <= cfg_data_i;
        rlss_pkg::CFG_END_LINE_HIGH: end_line_high_q <= cfg_data_i;
        rlss_pkg::CFG_READ_LIMIT:    read_limit_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---- execute ----
  logic [1:0]  upd, irq, back;
  logic [15:0] sx, sy, nl, rx, ry, rp;
  logic        flip, done, rclamp;
  logic [15:0] start_sum, lc_next, end_line;

  always_comb begin
    armed_d         = armed_q;
    in_progress_d   = in_progress_q;
    first_line_d    = first_line_q;
    selected_side_d = selected_side_q;
    active_side_d   = active_side_q;
    start_line_d    = start_line_q;
    line_count_d    = line_count_q;
    upd    = rlss_pkg::UPD_NONE;
    irq    = rlss_pkg::IRQ_KEEP;
    back   = rlss_pkg::BACK_KEEP;
    sx     = '0;
    sy     = '0;
    nl     = '0;
    rx     = '0;
    ry     = '0;
    rp     = '0;
    flip   = 1'b0;
    done   = 1'b0;
    rclamp = 1'b0;

    start_sum = 16'(display_start_q) + rd_a_q.y +
                (crt_timing_q ? 16'd0 : 16'(sprite_offset_q));
    lc_next   = line_count_q + 16'(line_step_q);
    end_line  = crt_timing_q ? 16'(end_line_high_q) : 16'(end_line_low_q);

    unique case (rlss_pkg::op_e'(op_q))
      rlss_pkg::OP_FRAME_START: begin
        if (armed_q) begin
          back = rlss_pkg::BACK_ON;
          if (!in_progress_q) begin
            start_line_d  = start_sum;
            line_count_d  = start_sum;
            active_side_d = selected_side_q;
            first_line_d  = 1'b1;
            irq           = rlss_pkg::IRQ_START;
            nl            = start_sum;
            upd           = rlss_pkg::UPD_XY;
            sx            = rlss_pkg::TOP_SCROLL_X;
            sy            = rd_b_q.y;
          end
        end
        flip = !in_progress_q;
      end
      rlss_pkg::OP_LINE_EVENT: begin
        if (lc_next < end_line) begin
          in_progress_d = 1'b1;
          line_count_d  = lc_next;
          upd           = rlss_pkg::UPD_XY;
          sx            = rd_a_q.x;
          nl            = lc_next;
          if (first_line_q) begin
            first_line_d = 1'b0;
            back         = rlss_pkg::BACK_OFF;
            sy           = rd_a_q.y;
          end else begin
            sy = rd_a_q.y + rd_a_q.pattern;
          end
        end else begin
          in_progress_d = 1'b0;
          line_count_d  = start_line_q;
          nl            = rlss_pkg::PARKED_LINE;
          irq           = rlss_pkg::IRQ_STOP;
          upd           = rlss_pkg::UPD_Y_ONLY;
          sy            = end_line;
          done          = 1'b1;
        end
      end
      rlss_pkg::OP_SELECT_SIDE: begin
        armed_d         = 1'b1;
        selected_side_d = side_q;
      end
      rlss_pkg::OP_READ_ENTRY: begin
        rx     = rd_a_q.x;
        ry     = rd_a_q.y;
        rp     = rd_a_q.pattern;
        rclamp = clamped_q;
      end
      default: ;  // table write done at load; unknown codes do nothing
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q         <= 1'b0;
      in_progress_q   <= 1'b0;
      first_line_q    <= 1'b1;
      selected_side_q <= 1'b0;
      active_side_q   <= 1'b0;
      start_line_q    <= '0;
      line_count_q    <= '0;
    end else if (cmd_i.commit) begin
      armed_q         <= armed_d;
      in_progress_q   <= in_progress_d;
      first_line_q    <= first_line_d;
      selected_side_q <= selected_side_d;
      active_side_q   <= active_side_d;
      start_line_q    <= start_line_d;
      line_count_q    <= line_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      scroll_update_o    <= upd;
      scroll_x_o         <= sx;
      scroll_y_o         <= sy;
      next_line_o        <= nl;
      line_irq_control_o <= irq;
      back_layer_o       <= back;
      flip_request_o     <= flip;
      sequence_done_o    <= done;
      read_x_o           <= rx;
      read_y_o           <= ry;
      read_pattern_o     <= rp;
      read_clamped_o     <= rclamp;
    end
  end

`ifndef SYNTH
  a_state_only_on_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> ($stable(line_count_q) && $stable(in_progress_q)))
    else $error("sequencer state changed outside commit");

  a_run_start_resets_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && rlss_pkg::op_e'(op_q) == rlss_pkg::OP_LINE_EVENT && !first_line_q)
    |=> !first_line_q)
    else $error("first line flag set by a line event");

  a_done_stops_irq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.commit) && sequence_done_o |-> (line_irq_control_o == rlss_pkg::IRQ_STOP))
    else $error("run ended without stopping line interrupts");
`endif

endmodule

// ===== hdl/raster_line_scroll_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster_line_scroll_sequencer
// Per-line background scroll sequencer driven from a table of scroll words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per
//   operation: frame start, line event, table write, select side, read.
//   Every transaction yields exactly one result on the output channel
//   (out_valid_o / out_stall_i), in order.
//   Timing: a transaction is accepted in the idle cycle; the table is read
//   at that edge into a register, and the execute state then loads the
//   result register once it is free. A new transaction is not accepted
//   until the current one has executed, since the registered table read
//   is followed by the execute step.
//   If the result register still holds an untaken result, execution waits
//   and in_stall_o stays high until the receiver takes it.
//   Configuration (cfg_valid_i / cfg_ready_o) is always ready; write only
//   while no transaction is in flight.
//   Reset clears sequencer state and loads the register defaults. Table
//   contents are undefined until written. TABLE_DEPTH is a power of two.
// ----------------------------------------------------------------------------
module raster_line_scroll_sequencer #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic        side_i,
  input  logic [8:0]  entry_index_i,
  input  logic [15:0] entry_x_i,
  input  logic [15:0] entry_y_i,
  input  logic [15:0] entry_pattern_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  scroll_update_o,
  output logic [15:0] scroll_x_o,
  output logic [15:0] scroll_y_o,
  output logic [15:0] next_line_o,
  output logic [1:0]  line_irq_control_o,
  output logic [1:0]  back_layer_o,
  output logic        flip_request_o,
  output logic        sequence_done_o,
  output logic [15:0] read_x_o,
  output logic [15:0] read_y_o,
  output logic [15:0] read_pattern_o,
  output logic        read_clamped_o
);

  rlss_pkg::ctrl_cmd_t cmd;

  // Config port never back-pressures.
  assign cfg_ready_o = 1'b1;

  // Controller: accept / execute sequencing and result handshake.
  rlss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Datapath: table, registers, sequencer state, result register.
  rlss_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .side_i             (side_i),
    .entry_index_i      (entry_index_i),
    .entry_x_i          (entry_x_i),
    .entry_y_i          (entry_y_i),
    .entry_pattern_i    (entry_pattern_i),
    .scroll_update_o    (scroll_update_o),
    .scroll_x_o         (scroll_x_o),
    .scroll_y_o         (scroll_y_o),
    .next_line_o        (next_line_o),
    .line_irq_control_o (line_irq_control_o),
    .back_layer_o       (back_layer_o),
    .flip_request_o     (flip_request_o),
    .sequence_done_o    (sequence_done_o),
    .read_x_o           (read_x_o),
    .read_y_o           (read_y_o),
    .read_pattern_o     (read_pattern_o),
    .read_clamped_o     (read_clamped_o)
  );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the raster line scroll sequencer. A shadow copy of
// the sequencer state and the scroll table tracks every accepted transaction
// and predicts its result. Results are checked field by field, in order.
// Stimulus is a full table load, a directed walk through the run states, and
// random traffic, mostly frames (frame start plus line events), under several
// register settings. Both channels idle at random but in the last stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int TABLE_DEPTH   = 512;
  localparam int SETTLE_CYCLES = 4;
  localparam int STUCK_LIMIT   = 2000;  // cycles with no transaction at all

  // Operation codes the block leaves undecoded
  localparam logic [2:0] OP_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] OP_UNKNOWN_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic        side;
    logic [8:0]  index;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] pattern;
  } item_t;

  typedef struct packed {
    logic [1:0]  update;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [15:0] next_line;
    logic [1:0]  irq;
    logic [1:0]  back;
    logic        flip;
    logic        done;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] rp;
    logic        clamped;
  } result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT connections
  // --------------------------------------------------------------------------
  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [9:0]  cfg_data  = '0;

  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [2:0]  operation     = '0;
  logic        side          = 1'b0;
  logic [8:0]  entry_index   = '0;
  logic [15:0] entry_x       = '0;
  logic [15:0] entry_y       = '0;
  logic [15:0] entry_pattern = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  scroll_update;
  logic [15:0] scroll_x;
  logic [15:0] scroll_y;
  logic [15:0] next_line;
  logic [1:0]  line_irq_control;
  logic [1:0]  back_layer;
  logic        flip_request;
  logic        sequence_done;
  logic [15:0] read_x;
  logic [15:0] read_y;
  logic [15:0] read_pattern;
  logic        read_clamped;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  raster_line_scroll_sequencer #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .side_i             (side),
    .entry_index_i      (entry_index),
    .entry_x_i          (entry_x),
    .entry_y_i          (entry_y),
    .entry_pattern_i    (entry_pattern),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .scroll_update_o    (scroll_update),
    .scroll_x_o         (scroll_x),
    .scroll_y_o         (scroll_y),
    .next_line_o        (next_line),
    .line_irq_control_o (line_irq_control),
    .back_layer_o       (back_layer),
    .flip_request_o     (flip_request),
    .sequence_done_o    (sequence_done),
    .read_x_o           (read_x),
    .read_y_o           (read_y),
    .read_pattern_o     (read_pattern),
    .read_clamped_o     (read_clamped)
  );

  // --------------------------------------------------------------------------
  // Shadow sequencer: table, run state and register copies
  // --------------------------------------------------------------------------
  rlss_pkg::entry_t shadow_tab [TABLE_DEPTH];
  logic        armed    = 1'b0;
  logic        in_run   = 1'b0;
  logic        first_ln = 1'b1;
  logic        sel_side = 1'b0;
  logic        act_side = 1'b0;
  logic [15:0] start_ln = '0;
  logic [15:0] line_cnt = '0;

  logic        crt_mode   = rlss_pkg::RST_CRT_TIMING;
  logic [9:0]  disp_start = rlss_pkg::RST_DISPLAY_START;
  logic [7:0]  step       = rlss_pkg::RST_LINE_STEP;
  logic [7:0]  spr_off    = rlss_pkg::RST_SPRITE_OFFSET;
  logic [9:0]  end_lo     = rlss_pkg::RST_END_LINE_LOW;
  logic [9:0]  end_hi     = rlss_pkg::RST_END_LINE_HIGH;
  logic [9:0]  rd_limit   = rlss_pkg::RST_READ_LIMIT;

  item_t   item_backlog [$];  // transactions not yet presented
  result_t owed_results [$];  // results the block still has to deliver
  int      fault_count = 0;

  // Advance the shadow sequencer by one accepted transaction; returns the
  // result the block must produce for it. Undriven result fields stay zero.
  function automatic result_t apply_item(item_t it);
    result_t          r;
    rlss_pkg::entry_t e;
    logic [15:0]      sum;
    logic [15:0]      ofs;
    logic [15:0]      end_ln;
    logic [9:0]       rd_idx;
    r = '0;
    case (it.op)
      rlss_pkg::OP_FRAME_START: begin
        if (armed) begin
          r.back = rlss_pkg::BACK_ON;
          // new run only when the previous one has ended
          if (!in_run) begin
            sum = {6'd0, disp_start} + shadow_tab[TABLE_DEPTH - 2 + sel_side].y;
            if (!crt_mode) sum = sum + {8'd0, spr_off};
            start_ln    = sum;
            line_cnt    = sum;
            act_side    = sel_side;
            first_ln    = 1'b1;
            r.irq       = rlss_pkg::IRQ_START;
            r.next_line = sum;
            r.update    = rlss_pkg::UPD_XY;
            r.sx        = rlss_pkg::TOP_SCROLL_X;
            r.sy        = shadow_tab[TABLE_DEPTH - 4 + sel_side].y;
          end
        end
        if (!in_run) r.flip = 1'b1;
      end
      rlss_pkg::OP_LINE_EVENT: begin
        // entry offset wraps at 16 bits, then at the table depth
        ofs      = line_cnt - start_ln + {15'd0, act_side};
        e        = shadow_tab[ofs % TABLE_DEPTH];
        end_ln   = crt_mode ? {6'd0, end_hi} : {6'd0, end_lo};
        line_cnt = line_cnt + {8'd0, step};
        if (line_cnt < end_ln) begin
          in_run = 1'b1;
          if (first_ln) begin
            first_ln = 1'b0;
            r.back   = rlss_pkg::BACK_OFF;
            r.sy     = e.y;
          end else begin
            r.sy = e.y + e.pattern;
          end
          r.update    = rlss_pkg::UPD_XY;
          r.sx        = e.x;
          r.next_line = line_cnt;
        end else begin
          in_run      = 1'b0;
          line_cnt    = start_ln;
          r.next_line = rlss_pkg::PARKED_LINE;
          r.irq       = rlss_pkg::IRQ_STOP;
          r.update    = rlss_pkg::UPD_Y_ONLY;
          r.sy        = end_ln;
          r.done      = 1'b1;
        end
      end
      rlss_pkg::OP_TABLE_WRITE: begin
        shadow_tab[it.index % TABLE_DEPTH] = '{x: it.x, y: it.y, pattern: it.pattern};
      end
      rlss_pkg::OP_SELECT_SIDE: begin
        armed    = 1'b1;
        sel_side = it.side;
      end
      rlss_pkg::OP_READ_ENTRY: begin
        rd_idx = {it.index, 1'b0} + {9'd0, sel_side};
        if (rd_idx >= rd_limit) begin
          rd_idx    = (rd_limit == 10'd0) ? 10'd0 : rd_limit - 10'd1;
          r.clamped = 1'b1;
        end
        e    = shadow_tab[rd_idx % TABLE_DEPTH];
        r.rx = e.x;
        r.ry = e.y;
        r.rp = e.pattern;
      end
      default: ;  // undecoded op: no state change, all-zero result
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input driver. Pops the backlog, holds the payload while stalled, and
  // inserts random idle bursts after accepted transactions.
  // --------------------------------------------------------------------------
  item_t cur_item;
  logic  driving   = 1'b0;  // a transaction is on the input channel
  logic  idle_on   = 1'b1;  // random idling on both channels
  int    gap_left  = 0;
  int    stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      driving  = 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_results.push_back(apply_item(cur_item));
        driving = 1'b0;
        if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 7);
      end
      if (!driving) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (item_backlog.size() > 0) begin
          cur_item       = item_backlog.pop_front();
          driving        = 1'b1;
          operation     <= cur_item.op;
          side          <= cur_item.side;
          entry_index   <= cur_item.index;
          entry_x       <= cur_item.x;
          entry_y       <= cur_item.y;
          entry_pattern <= cur_item.pattern;
        end
      end
      in_valid <= driving;
    end
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7);
    end
    out_stall <= (stall_left > 0);
  end

  // --------------------------------------------------------------------------
  // Result monitor: each result transaction against the oldest owed result
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        fault_count++;
        $display("%0t: result transaction expected none, actual update %0d",
                 $time, scroll_update);
      end else begin
        want = owed_results.pop_front();
        check_field("scroll_update", 16'(want.update), 16'(scroll_update));
        check_field("scroll_x", want.sx, scroll_x);
        check_field("scroll_y", want.sy, scroll_y);
        check_field("next_line", want.next_line, next_line);
        check_field("line_irq_control", 16'(want.irq), 16'(line_irq_control));
        check_field("back_layer", 16'(want.back), 16'(back_layer));
        check_field("flip_request", 16'(want.flip), 16'(flip_request));
        check_field("sequence_done", 16'(want.done), 16'(sequence_done));
        check_field("read_x", want.rx, read_x);
        check_field("read_y", want.ry, read_y);
        check_field("read_pattern", want.rp, read_pattern);
        check_field("read_clamped", 16'(want.clamped), 16'(read_clamped));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any accepted transaction on any channel resets the count
  // --------------------------------------------------------------------------
  int stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic item_t noise_item(logic [2:0] op);
    item_t it;
    it.op      = op;
    it.side    = 1'($urandom);
    it.index   = 9'($urandom);
    it.x       = 16'($urandom);
    it.y       = 16'($urandom);
    it.pattern = 16'($urandom);
    return it;
  endfunction

  function automatic void enqueue(logic [2:0] op, logic sd, logic [8:0] idx,
                                  logic [15:0] x = '0, logic [15:0] y = '0,
                                  logic [15:0] p = '0);
    item_backlog.push_back('{op: op, side: sd, index: idx, x: x, y: y, pattern: p});
  endfunction

  // Block is idle once nothing is queued, presented or owed
  task automatic wait_drained();
    while (item_backlog.size() != 0 || driving || owed_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(rlss_pkg::cfg_reg_e idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rlss_pkg::CFG_CRT_TIMING:    crt_mode   = val[0];
      rlss_pkg::CFG_DISPLAY_START: disp_start = val;
      rlss_pkg::CFG_LINE_STEP:     step       = val[7:0];
      rlss_pkg::CFG_SPRITE_OFFSET: spr_off    = val[7:0];
      rlss_pkg::CFG_END_LINE_LOW:  end_lo     = val;
      rlss_pkg::CFG_END_LINE_HIGH: end_hi     = val;
      rlss_pkg::CFG_READ_LIMIT:    rd_limit   = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic crt, input logic [9:0] disp,
                                input logic [7:0] stp, input logic [7:0] off,
                                input logic [9:0] elo, input logic [9:0] ehi,
                                input logic [9:0] rlim);
    wait_drained();
    write_reg(rlss_pkg::CFG_CRT_TIMING, {9'd0, crt});
    write_reg(rlss_pkg::CFG_DISPLAY_START, disp);
    write_reg(rlss_pkg::CFG_LINE_STEP, {2'd0, stp});
    write_reg(rlss_pkg::CFG_SPRITE_OFFSET, {2'd0, off});
    write_reg(rlss_pkg::CFG_END_LINE_LOW, elo);
    write_reg(rlss_pkg::CFG_END_LINE_HIGH, ehi);
    write_reg(rlss_pkg::CFG_READ_LIMIT, rlim);
  endtask

  // Random traffic, mostly whole frames: a frame start followed by a burst
  // of line events, with table writes, reads, side selects and junk mixed in.
  // Reserved start-line entries are usually loaded so that the run ends
  // within a dozen or so line events under the current settings.
  task automatic queue_random(int n_items);
    int          made;
    int          pick;
    int          run_len;
    item_t       it;
    logic [15:0] end_ln;
    made = 0;
    while (made < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        it       = noise_item(rlss_pkg::OP_TABLE_WRITE);
        it.index = 9'(TABLE_DEPTH - 4 + $urandom_range(0, 3));
        if (it.index >= TABLE_DEPTH - 2 && $urandom_range(0, 3) != 0) begin
          end_ln = crt_mode ? {6'd0, end_hi} : {6'd0, end_lo};
          it.y   = 16'(end_ln - {6'd0, disp_start}
                       - (crt_mode ? 16'd0 : {8'd0, spr_off})
                       - $urandom_range(0, 12 * step));
        end
        item_backlog.push_back(it);
        made++;
      end else if (pick < 20) begin
        item_backlog.push_back(noise_item(rlss_pkg::OP_SELECT_SIDE));
        made++;
      end else if (pick < 28) begin
        item_backlog.push_back(noise_item(rlss_pkg::OP_TABLE_WRITE));
        made++;
      end else if (pick < 35) begin
        item_backlog.push_back(noise_item(rlss_pkg::OP_READ_ENTRY));
        made++;
      end else if (pick < 37) begin
        // no state change in the block, not counted
        item_backlog.push_back(noise_item(3'($urandom_range(OP_UNKNOWN_FIRST,
                                                             OP_UNKNOWN_LAST))));
      end else begin
        item_backlog.push_back(noise_item(rlss_pkg::OP_FRAME_START));
        made++;
        run_len = $urandom_range(1, 20);
        repeat (run_len) begin
          if ($urandom_range(0, 9) == 0) begin
            item_backlog.push_back(noise_item($urandom_range(0, 1)
                                              ? rlss_pkg::OP_READ_ENTRY
                                              : rlss_pkg::OP_TABLE_WRITE));
            made++;
          end
          item_backlog.push_back(noise_item(rlss_pkg::OP_LINE_EVENT));
          made++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    item_t it;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load every table entry first so no read ever hits an unwritten one
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      it       = noise_item(rlss_pkg::OP_TABLE_WRITE);
      it.index = 9'(i);
      item_backlog.push_back(it);
    end

    // Directed walk at reset settings (offset 16, end line 256, step 1)
    for (int c = OP_UNKNOWN_FIRST; c <= OP_UNKNOWN_LAST; c++)
      enqueue(3'(c), 1'b1, 9'h1FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    enqueue(rlss_pkg::OP_READ_ENTRY, 1'b0, 9'd0);
    enqueue(rlss_pkg::OP_READ_ENTRY, 1'b0, 9'd511);   // past the limit: clamped
    enqueue(rlss_pkg::OP_READ_ENTRY, 1'b0, 9'd255);
    enqueue(rlss_pkg::OP_FRAME_START, 1'b0, 9'd0);    // not armed: flip only
    enqueue(rlss_pkg::OP_TABLE_WRITE, 1'b0, 9'd510, 16'h0000, 16'd234, 16'h0000);  // start 250
    enqueue(rlss_pkg::OP_TABLE_WRITE, 1'b0, 9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF); // wraps
    enqueue(rlss_pkg::OP_TABLE_WRITE, 1'b0, 9'd508, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    enqueue(rlss_pkg::OP_TABLE_WRITE, 1'b0, 9'd509, 16'h0000, 16'h0000, 16'h0000);
    enqueue(rlss_pkg::OP_SELECT_SIDE, 1'b0, 9'd0);
    enqueue(rlss_pkg::OP_FRAME_START, 1'b0, 9'd0);
    enqueue(rlss_pkg::OP_FRAME_START, 1'b0, 9'd0);    // no line yet: restarts
    repeat (6) enqueue(rlss_pkg::OP_LINE_EVENT, 1'b0, 9'd0);  // five lines, then run ends
    enqueue(rlss_pkg::OP_LINE_EVENT, 1'b0, 9'd0);     // line event outside a run
    enqueue(rlss_pkg::OP_FRAME_START, 1'b0, 9'd0);    // mid-run: back layer only
    enqueue(rlss_pkg::OP_SELECT_SIDE, 1'b1, 9'd0);
    enqueue(rlss_pkg::OP_READ_ENTRY, 1'b0, 9'd255);
    repeat (5) enqueue(rlss_pkg::OP_LINE_EVENT, 1'b0, 9'd0);
    enqueue(rlss_pkg::OP_FRAME_START, 1'b0, 9'd0);    // side 1, start line wraps to 15
    enqueue(rlss_pkg::OP_LINE_EVENT, 1'b0, 9'd0);

    queue_random(100);

    apply_settings(1'b1, 10'd1023, 8'd255, 8'd255, 10'd0, 10'd1023, 10'd1);
    queue_random(150);

    apply_settings(1'b0, 10'd0, 8'd1, 8'd0, 10'd1023, 10'd0, 10'd512);
    queue_random(150);

    apply_settings(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                   10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                   10'($urandom_range(1, 512)));
    queue_random(200);

    apply_settings(1'b1, 10'd37, 8'd3, 8'd200, 10'd300, 10'd352, 10'd300);
    queue_random(150);

    // Last stretch at full rate, no idling on either side
    apply_settings(1'b0, 10'd5, 8'd7, 8'd16, 10'd256, 10'd352, 10'd512);
    idle_on = 1'b0;
    queue_random(100);

    wait_drained();
    if (fault_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
